// File: rtl/core/mats_pkg.sv
// shared constants for the two-way time series merge block
package mats_pkg;

	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned POINT_W   = TIME_W + VALUE_W;
	localparam int unsigned PROD_W    = 65;
	localparam int unsigned QUOT_W    = 41;
	localparam int unsigned CMD_W     = 2;

	localparam logic [PROD_W-1:0] QUOT_MAX = PROD_W'(1) << 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_RUN    = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

endpackage

// File: rtl/core/mats_ram.sv
// generic single write, single registered read port memory
module mats_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/mats_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module mats_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mats_pkg::PROD_W-1:0]       dividend,
	input  logic [mats_pkg::TIME_W-1:0]       divisor,
	output logic                              done,
	output logic [mats_pkg::PROD_W-1:0]       quotient
);

	localparam int unsigned TW = mats_pkg::TIME_W;
	localparam int unsigned PW = mats_pkg::PROD_W;
	localparam int unsigned NW = $clog2(PW + 1);

	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic [PW-1:0] dvd_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] dsr_q;
	logic [TW:0]   trial;
	logic          qbit;

	assign trial    = {rem_q, dvd_q[PW-1]};
	assign qbit     = trial >= {1'b0, dsr_q};
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PW-2:0], qbit};
			rem_q <= qbit ? TW'(trial - {1'b0, dsr_q}) : trial[TW-1:0];
		end
	end

endmodule

// File: rtl/core/merge_add_time_series_top.sv
// top level: point stores, merge sequencer, interpolation and output register
//
// channel  dir  tdata                                   tuser      tlast
// s_axis   in   point_time[31:0], point_value[63:32]    command    -
// m_axis   out  out_time[31:0], out_value[63:32]        overflow   last
//
// load beats are accepted back to back
// a run emits plain points directly, skips the divider for a zero-width interval and waits on
// the 65-step serial divider for each interpolated point; input is held off during a run
// reset clears the counts and the dropped flag; store contents are not cleared
// the output register frees as soon as the sink takes the beat
module merge_add_time_series_top #(
	parameter int unsigned DEPTH = mats_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // point_time, point_value
	input  logic [1:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_time, out_value
	output logic        m_axis_tuser,   // overflow
	output logic        m_axis_tlast
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned TW = mats_pkg::TIME_W;
	localparam int unsigned VW = mats_pkg::VALUE_W;
	localparam int unsigned PW = mats_pkg::POINT_W;
	localparam int unsigned XW = mats_pkg::PROD_W;
	localparam int unsigned QW = mats_pkg::QUOT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_LD, S_CMP, S_MUL, S_DST, S_DIV, S_EMIT
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_a_q, cnt_b_q, idx_a_q, idx_b_q;
	logic          drop_q;

	logic [TW-1:0] cur_at_q, cur_bt_q, prev_at_q, prev_bt_q;
	logic [VW-1:0] cur_av_q, cur_bv_q, prev_av_q, prev_bv_q;
	logic [TW-1:0] x0_q, x1_q, x_q, otime_q;
	logic [VW-1:0] y0_q, y1_q, own_q, res_q;
	logic          adv_a_q, adv_b_q;

	logic [XW-1:0] prod_q;
	logic [TW-1:0] aw_q;
	logic          neg_q, zw_q;

	logic [TW-1:0] out_time_q;
	logic [VW-1:0] out_value_q;
	logic          out_valid_q, out_last_q, out_ovf_q;

	logic          in_beat;
	mats_pkg::cmd_t cmd;
	logic [PW-1:0] rdata_a, rdata_b;
	logic          we_a, we_b;
	logic          a_left, b_left;
	logic          div_start, div_done;
	logic [XW-1:0] quot;
	logic          out_free;

	logic [TW:0]   dx, dw;
	logic [VW:0]   dy;
	logic [TW-1:0] ax, awm;
	logic [VW:0]   ay;
	logic [QW-1:0] qc;
	logic [42:0]   yq;
	logic [31:0]   interp;
	logic [VW:0]   own_sum;
	logic [CW-1:0] nidx_a, nidx_b;

	function automatic logic [31:0] sat32(input logic [42:0] v);
		logic signed [42:0] s;
		s = $signed(v);
		if (s > 43'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (s < -43'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	assign cmd           = mats_pkg::cmd_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign we_a          = in_beat && cmd == mats_pkg::CMD_LOAD_A && cnt_a_q < CW'(DEPTH);
	assign we_b          = in_beat && cmd == mats_pkg::CMD_LOAD_B && cnt_b_q < CW'(DEPTH);

	mats_ram #(.WIDTH(PW), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (idx_a_q[AW-1:0]),
		.rdata (rdata_a)
	);

	mats_ram #(.WIDTH(PW), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (idx_b_q[AW-1:0]),
		.rdata (rdata_b)
	);

	assign div_start = (state_q == S_DST) && !zw_q;

	mats_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (aw_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign a_left   = idx_a_q < cnt_a_q;
	assign b_left   = idx_b_q < cnt_b_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign nidx_a   = adv_a_q ? idx_a_q + CW'(1) : idx_a_q;
	assign nidx_b   = adv_b_q ? idx_b_q + CW'(1) : idx_b_q;

	assign dx  = {1'b0, x_q} - {1'b0, x0_q};
	assign dw  = {1'b0, x1_q} - {1'b0, x0_q};
	assign dy  = {y1_q[VW-1], y1_q} - {y0_q[VW-1], y0_q};
	assign ax  = dx[TW] ? TW'(-dx) : dx[TW-1:0];
	assign awm = dw[TW] ? TW'(-dw) : dw[TW-1:0];
	assign ay  = dy[VW] ? -dy : dy;

	assign qc      = (zw_q) ? '0 : ((quot > mats_pkg::QUOT_MAX) ? QW'(mats_pkg::QUOT_MAX)
	                                                          : quot[QW-1:0]);
	assign yq      = neg_q ? ({{11{y0_q[VW-1]}}, y0_q} - {2'b0, qc})
	                       : ({{11{y0_q[VW-1]}}, y0_q} + {2'b0, qc});
	assign interp  = sat32(yq);
	assign own_sum = {own_q[VW-1], own_q} + {interp[31], interp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			idx_a_q     <= '0;
			idx_b_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						case (cmd)
							mats_pkg::CMD_LOAD_A: begin
								if (we_a) cnt_a_q <= cnt_a_q + CW'(1);
								else drop_q <= 1'b1;
							end
							mats_pkg::CMD_LOAD_B: begin
								if (we_b) cnt_b_q <= cnt_b_q + CW'(1);
								else drop_q <= 1'b1;
							end
							mats_pkg::CMD_RUN: begin
								idx_a_q <= '0;
								idx_b_q <= '0;
								if (cnt_a_q == '0 && cnt_b_q == '0) begin
									drop_q <= 1'b0;
								end else begin
									state_q <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD:  state_q <= S_LD;
				S_LD:  state_q <= S_CMP;
				S_CMP: begin
					if (a_left && b_left && cur_at_q < cur_bt_q && idx_b_q != '0) begin
						state_q <= S_MUL;
					end else if (a_left && b_left && cur_bt_q < cur_at_q && idx_a_q != '0) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_MUL: state_q <= S_DST;
				S_DST: state_q <= zw_q ? S_EMIT : S_DIV;
				S_DIV: begin
					if (div_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						idx_a_q     <= nidx_a;
						idx_b_q     <= nidx_b;
						if (nidx_a == cnt_a_q && nidx_b == cnt_b_q) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LD: begin
				cur_at_q <= rdata_a[TW-1:0];
				cur_av_q <= rdata_a[PW-1:TW];
				cur_bt_q <= rdata_b[TW-1:0];
				cur_bv_q <= rdata_b[PW-1:TW];
			end
			S_CMP: begin
				zw_q  <= 1'b1;
				neg_q <= 1'b0;
				if (a_left && b_left && cur_at_q < cur_bt_q) begin
					otime_q <= cur_at_q;
					own_q   <= cur_av_q;
					res_q   <= cur_av_q;
					adv_a_q <= 1'b1;
					adv_b_q <= 1'b0;
					x0_q    <= prev_bt_q;
					y0_q    <= prev_bv_q;
					x1_q    <= cur_bt_q;
					y1_q    <= cur_bv_q;
					x_q     <= cur_at_q;
				end else if (a_left && b_left && cur_bt_q < cur_at_q) begin
					otime_q <= cur_bt_q;
					own_q   <= cur_bv_q;
					res_q   <= cur_bv_q;
					adv_a_q <= 1'b0;
					adv_b_q <= 1'b1;
					x0_q    <= prev_at_q;
					y0_q    <= prev_av_q;
					x1_q    <= cur_at_q;
					y1_q    <= cur_av_q;
					x_q     <= cur_bt_q;
				end else if (a_left && b_left) begin
					otime_q <= cur_bt_q;
					own_q   <= cur_av_q;
					res_q   <= sat32(43'(signed'({cur_av_q[VW-1], cur_av_q}
					                           + {cur_bv_q[VW-1], cur_bv_q})));
					adv_a_q <= 1'b1;
					adv_b_q <= 1'b1;
				end else if (a_left) begin
					otime_q <= cur_at_q;
					own_q   <= cur_av_q;
					res_q   <= cur_av_q;
					adv_a_q <= 1'b1;
					adv_b_q <= 1'b0;
				end else begin
					otime_q <= cur_bt_q;
					own_q   <= cur_bv_q;
					res_q   <= cur_bv_q;
					adv_a_q <= 1'b0;
					adv_b_q <= 1'b1;
				end
			end
			S_MUL: begin
				prod_q <= {{(XW-TW){1'b0}}, ax} * {{(XW-VW-1){1'b0}}, ay};
				aw_q   <= awm;
				zw_q   <= (dw == '0);
				neg_q  <= dx[TW] ^ dy[VW] ^ dw[TW];
			end
			S_EMIT: begin
				if (out_free) begin
					out_time_q  <= otime_q;
					out_value_q <= res_q;
					out_ovf_q   <= drop_q;
					out_last_q  <= (nidx_a == cnt_a_q && nidx_b == cnt_b_q);
					if (adv_a_q) begin
						prev_at_q <= cur_at_q;
						prev_av_q <= cur_av_q;
					end
					if (adv_b_q) begin
						prev_bt_q <= cur_bt_q;
						prev_bv_q <= cur_bv_q;
					end
				end
			end
			default: ;
		endcase
		if ((state_q == S_DST && zw_q) || (state_q == S_DIV && div_done)) begin
			res_q <= sat32({{10{own_sum[VW]}}, own_sum});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_value_q, out_time_q};
	assign m_axis_tuser  = out_ovf_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= CW'(DEPTH) && cnt_b_q <= CW'(DEPTH))
		else $error("store count beyond depth");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && cmd == mats_pkg::CMD_RUN && (cnt_a_q != '0 || cnt_b_q != '0))
		|=> !s_axis_tready)
		else $error("input not held off during run");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && nidx_a == cnt_a_q && nidx_b == cnt_b_q)
		|=> (cnt_a_q == '0 && cnt_b_q == '0 && m_axis_tlast))
		else $error("stores not emptied after final beat");
`endif

endmodule
